@@ design/sha256_stream_hasher_defines.svh @@
// Assertion macros for the SHA-256 stream hasher checker
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define SHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/shs_pkg.sv @@
// Package: SHA-256 constants, types and helper functions
`default_nettype none
package shs_pkg;
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic       init;       // load initial hash, clear count/length
        logic       wr_byte;    // write byte at fill position
        logic [7:0] wr_data;
        logic       add_len;    // add 8 to the bit length
        logic       ld_sched;   // load working variables from the hash words
        logic       round;      // one compression round
        logic       fold;       // add working vars into hash
        logic       pad_len;    // write length into bytes 56..63
        logic [5:0] t;          // round index
        logic       out_shift;  // rotate hash out
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic [6:0] fill;
    } t_stat;

    function automatic t_word ror(input t_word v, input int unsigned s);
        ror = (v >> s) | (v << (32 - s));
    endfunction

    function automatic t_word init_h(input logic [2:0] i);
        case (i)
            3'd0: init_h = 32'h6a09e667;
            3'd1: init_h = 32'hbb67ae85;
            3'd2: init_h = 32'h3c6ef372;
            3'd3: init_h = 32'ha54ff53a;
            3'd4: init_h = 32'h510e527f;
            3'd5: init_h = 32'h9b05688c;
            3'd6: init_h = 32'h1f83d9ab;
            default: init_h = 32'h5be0cd19;
        endcase
    endfunction

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
endpackage
`default_nettype wire

@@ design/shs_stream_if.sv @@
// Valid/ready channel interfaces for input and output items
`default_nettype none
interface shs_in_if;
    logic             valid;
    logic             ready;
    shs_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface shs_out_if;
    logic              valid;
    logic              ready;
    shs_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/shs_datapath.sv @@
// Datapath: schedule window doubling as block buffer, working variables, hash words
`default_nettype none
module shs_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire shs_pkg::t_ctrl i_ctrl,
    output shs_pkg::t_stat     o_stat,
    output shs_pkg::t_word     o_hash0
);
    import shs_pkg::*;

    t_word       r_w [16];
    t_word       r_v [8];
    t_word       r_h [8];
    logic [6:0]  r_fill;
    logic [63:0] r_len;

    t_word s0, s1, w_new, big0, big1, ch, maj, tmp1, tmp2, w_t;

    always_comb begin
        w_t   = r_w[0];
        s0    = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        big1  = ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        tmp1  = r_v[7] + big1 + ch + ROUND_K[i_ctrl.t] + w_t;
        big0  = ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        tmp2  = big0 + maj;
    end

    // message words fill byte by byte, big-endian; the rounds then shift the window
    always_ff @(posedge i_clk) begin
        if (i_ctrl.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end else if (i_ctrl.wr_byte) begin
            r_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_ctrl.wr_data;
        end else if (i_ctrl.pad_len) begin
            r_w[14] <= r_len[63:32];
            r_w[15] <= r_len[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_sched) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_ctrl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + tmp1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= tmp1 + tmp2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.init) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= init_h(3'(i));
            end
            r_fill <= '0;
            r_len  <= '0;
        end else begin
            if (i_ctrl.fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end else if (i_ctrl.out_shift) begin
                for (int i = 0; i < 7; i++) begin
                    r_h[i] <= r_h[i+1];
                end
                r_h[7] <= r_h[0];
            end
            if (i_ctrl.wr_byte) begin
                r_fill <= (r_fill[5:0] == 6'd63) ? 7'd0 : r_fill + 7'd1;
            end
            if (i_ctrl.add_len) begin
                r_len <= r_len + 64'd8;
            end
        end
    end

    assign o_stat.fill = r_fill;
    assign o_hash0     = r_h[0];
endmodule
`default_nettype wire

@@ design/shs_controller.sv @@
// Controller: command decode, padding sequence, rounds and digest output
`default_nettype none
module shs_controller (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    shs_in_if.sink              i_in,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output logic [2:0]          o_out_index,
    input  wire shs_pkg::t_stat i_stat,
    output shs_pkg::t_ctrl      o_ctrl
);
    import shs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_ROUND = 7'b0001000,
        S_FOLD  = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_t, n_t;
    logic [2:0] r_idx, n_idx;
    logic       r_fin, n_fin;   // finishing: padding in progress
    logic       r_lenb, n_lenb; // final block with length is loaded

    always_comb begin
        n_state = r_state;
        n_t     = r_t;
        n_idx   = r_idx;
        n_fin   = r_fin;
        n_lenb  = r_lenb;
        o_ctrl  = '0;
        o_ctrl.t = r_t;
        i_in.ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    case (i_in.payload.command)
                        CMD_START: o_ctrl.init = 1'b1;
                        CMD_DATA: begin
                            o_ctrl.wr_byte = 1'b1;
                            o_ctrl.wr_data = i_in.payload.data_byte;
                            o_ctrl.add_len = 1'b1;
                            if (i_stat.fill[5:0] == 6'd63) begin
                                n_state = S_LOAD;
                            end
                        end
                        CMD_FINISH: begin
                            o_ctrl.wr_byte = 1'b1;
                            o_ctrl.wr_data = 8'h80;
                            n_fin   = 1'b1;
                            n_lenb  = 1'b0;
                            // marker in the last byte fills the block
                            if (i_stat.fill[5:0] == 6'd63) begin
                                n_state = S_LOAD;
                            end else begin
                                n_state = S_PAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PAD: begin
                // fill zeros one byte a cycle up to 56 or 64
                if (i_stat.fill == 7'd56) begin
                    o_ctrl.pad_len = 1'b1;
                    n_lenb  = 1'b1;
                    n_state = S_LOAD;
                end else begin
                    o_ctrl.wr_byte = 1'b1;
                    o_ctrl.wr_data = 8'h00;
                    if (i_stat.fill[5:0] == 6'd63) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                o_ctrl.ld_sched = 1'b1;
                n_t     = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_ctrl.round = 1'b1;
                n_t = r_t + 6'd1;
                if (r_t == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_ctrl.fold = 1'b1;
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_lenb) begin
                    n_idx   = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_ctrl.out_shift = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                o_ctrl.init = 1'b1;
                n_fin   = 1'b0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_t     <= '0;
            r_idx   <= '0;
            r_fin   <= 1'b0;
            r_lenb  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_t     <= n_t;
            r_idx   <= n_idx;
            r_fin   <= n_fin;
            r_lenb  <= n_lenb;
        end
    end

    assign o_out_index = r_idx;
endmodule
`default_nettype wire

@@ design/sha256_stream_hasher.sv @@
// Top level: SHA-256 stream hasher, one message byte per item
//
//  channel   dir  payload                              handshake
//  i_in      in   command[1:0], data_byte[7:0]         valid/ready
//  o_out     out  digest_word[31:0], word_index, last  valid/ready
//
// Start and data items are taken in the idle state; the 64th byte of a block
// starts a compression (load, 64 rounds of the single round unit, fold).
// Finish writes the marker, the zero fill and the length into one or two
// blocks and compresses each, then eight output items follow, one per cycle
// while o_out.ready is high, and the initial hash is reloaded.
// Synchronous reset loads the initial hash and clears count and length.
// Input is taken only when idle: not while padding, while a block is compressed or the digest drains.
`default_nettype none
module sha256_stream_hasher (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    shs_in_if.sink    i_in,
    shs_out_if.source o_out
);
    import shs_pkg::*;

    t_ctrl      ctrl;
    t_stat      stat;
    t_word      hash0;
    logic [2:0] idx;

    shs_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_index (idx),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    shs_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_stat  (stat),
        .o_hash0 (hash0)
    );

    assign o_out.payload.digest_word = hash0;
    assign o_out.payload.word_index  = idx;
    assign o_out.payload.last        = (idx == 3'd7);
endmodule
`default_nettype wire

@@ design/shs_checker.sv @@
// Port checker for the SHA-256 stream hasher, bound to the top level
`default_nettype none
`include "sha256_stream_hasher_defines.svh"
module shs_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [2:0] out_index,
    input wire logic out_last
);
    `SHS_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, out_valid, !in_ready)
    `SHS_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, out_valid, out_last == (out_index == 3'd7))
    `SHS_ASSERT_NXT(a_idx_step, i_clk, i_rst_n, out_valid && out_ready && !out_last, out_valid && out_index == $past(out_index) + 3'd1)
    `SHS_ASSERT_NXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_index))
endmodule

bind sha256_stream_hasher shs_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_index (o_out.payload.word_index),
    .out_last  (o_out.payload.last)
);
`default_nettype wire
